@@ rtl/bswq_pkg.sv @@
// ----------------------------------------------------------------------------
// bswq_pkg - shared types and codes for the semaphore wait-queue table
// Command and status codes, controller states and the control/status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package bswq_pkg;

  // request command codes (code 3 is unused and answers no-such-semaphore)
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_WAIT   = 2'd1;
  localparam logic [1:0] CMD_POST   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_ACQUIRED = 3'd1;
  localparam logic [2:0] ST_BLOCKED  = 3'd2;
  localparam logic [2:0] ST_POSTED   = 3'd3;
  localparam logic [2:0] ST_NOSEM    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // capture request, read entry memory
    logic commit;      // write back entry / queue slot
    logic wake_read;   // read head waiter from queue memory
    logic load_result; // load output register
    logic sel_wake;    // result is a wake-up of the head waiter
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic wake_needed; // post on a semaphore with waiters
    logic out_free;    // output register can take a result this cycle
  } dp_sts_t;

endpackage

@@ rtl/bswq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bswq_ctrl - request sequencer
// Accepts one request, lets the datapath execute it and, for a post that
// releases a waiter, waits for the queue read before loading the result.
// ----------------------------------------------------------------------------
module bswq_ctrl
  import bswq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.wake_needed) begin
          state_nxt = S_WAKE;
        end else if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WAKE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        // held off while reset is applied, so no request is taken and lost
        in_stall   = !rst_n;
        cmd.accept = in_valid && rst_n;
      end
      S_EXEC: begin
        if (sts.wake_needed) begin
          cmd.commit    = 1'b1;
          cmd.wake_read = 1'b1;
        end else if (sts.out_free) begin
          cmd.commit      = 1'b1;
          cmd.load_result = 1'b1;
        end
      end
      S_WAKE: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          cmd.sel_wake    = 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a result never overwrites one still waiting at the output
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> sts.out_free)
    else $error("result loaded while output register busy");

  // wake-up phase only ever follows execution of a post
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAKE) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_WAKE))
    else $error("wake phase entered out of sequence");
`endif

endmodule

@@ rtl/bswq_dp.sv @@
// ----------------------------------------------------------------------------
// bswq_dp - semaphore table datapath
// Entry memory (value, queue pointers, count), existence flags, wait-queue
// memory, request registers and the output register.
// ----------------------------------------------------------------------------
module bswq_dp
  import bswq_pkg::*;
#(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int PID_BITS    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_sts_t    sts,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_sem_id,
  input  logic       in_init_value,
  input  logic [7:0] in_caller_pid,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic       out_woken_valid,
  output logic [7:0] out_woken_pid
);

  localparam int SEM_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int WS_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int WS_AW    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // storage
  logic [NUM_SEMS-1:0] exists_r;
  logic                val_mem  [NUM_SEMS];
  logic [PTR_W-1:0]    head_mem [NUM_SEMS];
  logic [PTR_W-1:0]    tail_mem [NUM_SEMS];
  logic [CNT_W-1:0]    cnt_mem  [NUM_SEMS];
  logic [PID_BITS-1:0] ws_mem   [WS_DEPTH];

  // request and entry read registers
  logic [1:0]          op_r;
  logic [SEM_W-1:0]    idx_r;
  logic                init_r;
  logic [PID_BITS-1:0] pid_r;
  logic                in_range_r;
  logic                known_r;
  logic                val_r;
  logic [PTR_W-1:0]    head_r;
  logic [PTR_W-1:0]    tail_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PID_BITS-1:0] ws_rd_r;

  // output register
  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic       out_woken_valid_r;
  logic [7:0] out_woken_pid_r;

  // input conversion
  logic [SEM_W+3:0]    idx_ext;
  logic [SEM_W-1:0]    in_idx;
  logic                in_range;
  logic [PID_BITS+7:0] pid_ext;
  logic [PID_BITS+7:0] wpid_ext;

  // execute logic
  logic                ent_we;
  logic                val_nxt;
  logic [PTR_W-1:0]    head_nxt;
  logic [PTR_W-1:0]    tail_nxt;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                ws_we;
  logic [2:0]          res_status;
  logic                wake_needed;
  logic [PTR_W-1:0]    ws_ptr;
  logic [WS_AW-1:0]    ws_addr;

  assign idx_ext  = {SEM_W'(0), in_sem_id};
  assign in_idx   = idx_ext[SEM_W-1:0];
  assign in_range = 32'(in_sem_id) < 32'(NUM_SEMS);
  assign pid_ext  = {PID_BITS'(0), in_caller_pid};
  assign wpid_ext = {8'(0), ws_rd_r};

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_cmd;
      idx_r      <= in_idx;
      init_r     <= in_init_value;
      pid_r      <= pid_ext[PID_BITS-1:0];
      in_range_r <= in_range;
      known_r    <= in_range && exists_r[in_idx];
      val_r      <= val_mem[in_idx];
      head_r     <= head_mem[in_idx];
      tail_r     <= tail_mem[in_idx];
      cnt_r      <= cnt_mem[in_idx];
    end
  end

  always_comb begin
    ent_we      = 1'b0;
    ws_we       = 1'b0;
    wake_needed = 1'b0;
    val_nxt     = val_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    res_status  = ST_NOSEM;
    ws_ptr      = tail_r;
    case (op_r)
      CMD_CREATE: begin
        if (in_range_r) begin
          ent_we     = 1'b1;
          val_nxt    = init_r;
          head_nxt   = '0;
          tail_nxt   = '0;
          cnt_nxt    = '0;
          res_status = ST_CREATED;
        end
      end
      CMD_WAIT: begin
        if (known_r) begin
          if (val_r) begin
            ent_we     = 1'b1;
            val_nxt    = 1'b0;
            res_status = ST_ACQUIRED;
          end else if (cnt_r >= CNT_FULL) begin
            res_status = ST_FULL;
          end else begin
            ent_we     = 1'b1;
            ws_we      = 1'b1;
            tail_nxt   = next_slot(tail_r);
            cnt_nxt    = cnt_r + CNT_W'(1);
            res_status = ST_BLOCKED;
          end
        end
      end
      CMD_POST: begin
        if (known_r) begin
          ent_we     = 1'b1;
          res_status = ST_POSTED;
          if (cnt_r != '0) begin
            wake_needed = 1'b1;
            ws_ptr      = head_r;
            head_nxt    = next_slot(head_r);
            cnt_nxt     = cnt_r - CNT_W'(1);
          end else begin
            val_nxt = 1'b1;
          end
        end
      end
      default: res_status = ST_NOSEM;
    endcase
  end

  // queue slot of semaphore idx_r
  assign ws_addr = WS_AW'(32'(idx_r) * 32'(QUEUE_DEPTH) + 32'(ws_ptr));

  always_ff @(posedge clk) begin
    if (cmd.commit && ent_we) begin
      val_mem[idx_r]  <= val_nxt;
      head_mem[idx_r] <= head_nxt;
      tail_mem[idx_r] <= tail_nxt;
      cnt_mem[idx_r]  <= cnt_nxt;
    end
    if (cmd.commit && ws_we) begin
      ws_mem[ws_addr] <= pid_r;
    end
    if (cmd.wake_read) begin
      ws_rd_r <= ws_mem[ws_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exists_r <= '0;
    end else if (cmd.commit && op_r == CMD_CREATE && in_range_r) begin
      exists_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      if (cmd.sel_wake) begin
        out_status_r      <= ST_POSTED;
        out_woken_valid_r <= 1'b1;
        out_woken_pid_r   <= wpid_ext[7:0];
      end else begin
        out_status_r      <= res_status;
        out_woken_valid_r <= 1'b0;
        out_woken_pid_r   <= '0;
      end
    end
  end

  assign sts.wake_needed = wake_needed;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_woken_valid = out_woken_valid_r;
  assign out_woken_pid   = out_woken_pid_r;

`ifndef SYNTHESIS
  // a released waiter only ever comes with a posted status
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_woken_valid_r) |-> (out_status_r == ST_POSTED))
    else $error("woken process reported without posted status");

  // queue occupancy written back never exceeds the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && ent_we) |-> (cnt_nxt <= CNT_FULL))
    else $error("wait queue count overflow");
`endif

endmodule

@@ rtl/binary_semaphore_wait_queue_table.sv @@
// ----------------------------------------------------------------------------
// binary_semaphore_wait_queue_table - binary semaphores with FIFO wait queues
// Table of binary semaphores addressed by id, each with its own queue of
// blocked process ids; create, wait and post requests give one result each.
// ----------------------------------------------------------------------------
// One request at a time: a request is accepted, with its entry read from
// the entry memory, and then executed against that entry; a post that
// releases a waiter adds a wake-up step, the registered read of the head
// slot in the wait-queue memory. The result sits in an output register,
// so the next request is accepted while the last result waits to be
// taken. Existence flags are flip-flops cleared by reset; the entry and
// queue memories need no clearing pass and the block is ready straight out
// of reset. Status codes: 0 created, 1 acquired, 2 blocked, 3 posted,
// 4 no such semaphore (id out of range, never created, or unused command),
// 5 queue full. woken_pid reads 0 unless woken_valid is set. Only the low
// PID_BITS bits of a caller id are kept.
// ----------------------------------------------------------------------------
module binary_semaphore_wait_queue_table
  import bswq_pkg::*;
#(
  parameter int NUM_SEMS    = 16, // semaphores in the table, 1..256
  parameter int QUEUE_DEPTH = 8,  // waiters per semaphore, 1..256
  parameter int PID_BITS    = 8   // stored process id width, 1..16
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_sem_id,
  input  logic       in_init_value,
  input  logic [7:0] in_caller_pid,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic       out_woken_valid,
  output logic [7:0] out_woken_pid
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: idle -> execute (-> wake-up read) -> idle
  bswq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table storage, execute logic and output register
  bswq_dp #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_sem_id       (in_sem_id),
    .in_init_value   (in_init_value),
    .in_caller_pid   (in_caller_pid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_woken_valid (out_woken_valid),
    .out_woken_pid   (out_woken_pid)
  );

endmodule

@@ tb/binary_semaphore_wait_queue_table_tb.sv @@
// ----------------------------------------------------------------------------
// binary_semaphore_wait_queue_table_tb - self-checking bench for the table
// Drives create, wait and post requests over the valid/stall channel with
// random gaps and back-pressure, mirrors the semaphore table and its wait
// queues in a scoreboard, and checks every result field by field in order.
// ----------------------------------------------------------------------------
import bswq_pkg::*;

typedef struct {
  logic [2:0] status;
  logic       woken_valid;
  logic [7:0] woken_pid;
} sem_result_t;

class sem_scoreboard;
  localparam int SEMS  = 16;
  localparam int DEPTH = 8;

  // mirrored table
  bit         exists [SEMS];
  bit         value  [SEMS];
  logic [7:0] waiters[SEMS][DEPTH];
  bit   [2:0] head   [SEMS];
  bit   [2:0] tail   [SEMS];
  bit   [3:0] count  [SEMS];

  sem_result_t expected_q[$];
  int          errors;

  function new();
    for (int s = 0; s < SEMS; s++) begin
      exists[s] = 0;
      value[s]  = 0;
      head[s]   = 0;
      tail[s]   = 0;
      count[s]  = 0;
      for (int d = 0; d < DEPTH; d++) waiters[s][d] = '0;
    end
    errors = 0;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function int pending();
    return expected_q.size();
  endfunction

  // Apply one accepted request to the mirror and queue its expected result.
  function void note_request(logic [1:0] cmd, logic [3:0] id, logic init,
                             logic [7:0] pid);
    sem_result_t r;
    r.status      = ST_NOSEM;
    r.woken_valid = 1'b0;
    r.woken_pid   = '0;
    case (cmd)
      CMD_CREATE: begin
        exists[id] = 1;
        value[id]  = init;
        head[id]   = 0;
        tail[id]   = 0;
        count[id]  = 0;
        r.status   = ST_CREATED;
      end
      CMD_WAIT: begin
        if (exists[id]) begin
          if (value[id]) begin
            value[id] = 0;
            r.status  = ST_ACQUIRED;
          end else if (count[id] == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            waiters[id][tail[id]] = pid;
            tail[id]  = tail[id] + 3'd1;
            count[id] = count[id] + 4'd1;
            r.status  = ST_BLOCKED;
          end
        end
      end
      CMD_POST: begin
        if (exists[id]) begin
          if (count[id] != 0) begin
            r.woken_valid = 1'b1;
            r.woken_pid   = waiters[id][head[id]];
            head[id]  = head[id] + 3'd1;
            count[id] = count[id] - 4'd1;
          end else begin
            value[id] = 1;
          end
          r.status = ST_POSTED;
        end
      end
      default: ;
    endcase
    expected_q.push_back(r);
  endfunction

  task check_result(logic [2:0] status, logic woken_valid, logic [7:0] woken_pid);
    sem_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result with no request outstanding (status %0d)", status));
    end else begin
      e = expected_q.pop_front();
      if (status !== e.status)
        report($sformatf("status: expected %0d, got %0d", e.status, status));
      if (woken_valid !== e.woken_valid)
        report($sformatf("woken_valid: expected %0d, got %0d", e.woken_valid,
                         woken_valid));
      if (woken_pid !== e.woken_pid)
        report($sformatf("woken_pid: expected 0x%02h, got 0x%02h", e.woken_pid,
                         woken_pid));
    end
  endtask
endclass

module binary_semaphore_wait_queue_table_tb;

  localparam logic [1:0] CMD_UNUSED  = 2'd3; // answers no-such-semaphore
  localparam int         RAND_ITEMS  = 1150;
  localparam int         IDLE_LIMIT  = 2000; // cycles with no handshake at all
  localparam int         LONG_HOLD   = 150;  // receiver hold-off, fills the block
  localparam int         DRAIN_CYCLES = 20;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd        = '0;
  logic [3:0] in_sem_id     = '0;
  logic       in_init_value = 1'b0;
  logic [7:0] in_caller_pid = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [2:0] out_status;
  logic       out_woken_valid;
  logic [7:0] out_woken_pid;

  sem_scoreboard sb = new();

  // handshake between the request driver and the result sink
  bit long_hold_req = 0;
  int send_calm     = 0; // requests left to send back to back
  int take_calm     = 0; // results left to take without stalling
  int idle_cycles   = 0;

  binary_semaphore_wait_queue_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_sem_id      (in_sem_id),
    .in_init_value  (in_init_value),
    .in_caller_pid  (in_caller_pid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_woken_valid(out_woken_valid),
    .out_woken_pid  (out_woken_pid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Draw an idle count; now and then start a run of zero-gap items.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  // Offer one request and hold it until the block takes it. Valid is only
  // lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(logic [1:0] cmd, logic [3:0] id, logic init,
                              logic [7:0] pid);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_sem_id     <= id;
    in_init_value <= init;
    in_caller_pid <= pid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(cmd, id, init, pid);
  endtask

  // Stop offering and wait for every outstanding result to come back.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic on a few hot semaphores, so queues fill up
  // and drain; the rest is stray ids and the unused command.
  task automatic send_random_request();
    int         r;
    logic [1:0] cmd;
    logic [3:0] id;
    r = $urandom_range(0, 99);
    if (r < 8)       cmd = CMD_CREATE;
    else if (r < 55) cmd = CMD_WAIT;
    else if (r < 95) cmd = CMD_POST;
    else             cmd = CMD_UNUSED;
    if ($urandom_range(0, 2) != 0) id = 4'($urandom_range(0, 3));
    else                           id = 4'($urandom_range(0, 15));
    send_request(cmd, id, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Result sink: random stalls per result, with an occasional long hold-off
  // asked for by the request driver.
  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = LONG_HOLD;
      end else begin
        hold = draw_gap(take_calm);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_status, out_woken_valid, out_woken_pid);
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // -- directed part --
    // nothing created yet: wait and post both miss, unused command misses
    send_request(CMD_WAIT,   4'd15, 1'b0, 8'hFF);
    send_request(CMD_POST,   4'd0,  1'b1, 8'h00);
    send_request(CMD_UNUSED, 4'd0,  1'b0, 8'h00);
    // lowest id free, highest id taken
    send_request(CMD_CREATE, 4'd0,  1'b1, 8'h00);
    send_request(CMD_CREATE, 4'd15, 1'b0, 8'hFF);
    // take, then two waiters queue up in order
    send_request(CMD_WAIT,   4'd0,  1'b0, 8'h00);
    send_request(CMD_WAIT,   4'd0,  1'b1, 8'hFF);
    send_request(CMD_WAIT,   4'd0,  1'b0, 8'hA5);
    // posts hand over to the waiters in FIFO order, then free it
    send_request(CMD_POST,   4'd0,  1'b0, 8'h00);
    send_request(CMD_POST,   4'd0,  1'b0, 8'h00);
    send_request(CMD_POST,   4'd0,  1'b0, 8'h00);
    // post on an already free semaphore leaves it free
    send_request(CMD_POST,   4'd0,  1'b0, 8'h00);
    send_request(CMD_WAIT,   4'd0,  1'b0, 8'h5A);
    // fill the queue on the taken semaphore, then one more is refused
    for (int i = 0; i < 9; i++)
      send_request(CMD_WAIT, 4'd15, 1'b0, 8'(8'h80 + i));
    // recreate over a full queue: waiters dropped without a wake-up
    send_request(CMD_CREATE, 4'd15, 1'b0, 8'h00);
    send_request(CMD_POST,   4'd15, 1'b0, 8'h00);
    send_request(CMD_UNUSED, 4'd15, 1'b1, 8'hFF);

    // -- random part --
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) long_hold_req = 1;      // block fills, input stalls
      if (n == (2 * RAND_ITEMS) / 3) wait_all_results(); // sender pauses, block empties
      send_random_request();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) $display("SUCCESS");
    else                $display("FAILURE");
    $finish;
  end

endmodule
